/* hw/rtl/pppt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pppt_pkg
// Shared types, constants and tables of the pure pursuit path tracker.
// ----------------------------------------------------------------------------
package pppt_pkg;

  localparam int unsigned MaxWaypoints = 256;
  localparam int unsigned WpIdxW       = $clog2(MaxWaypoints);
  localparam int unsigned WpCntW       = WpIdxW + 1;

  localparam int unsigned CordicSteps  = 24;
  localparam int unsigned CordicStepW  = 5;
  localparam int unsigned CordicW      = 36;

  localparam logic signed [CordicW-1:0] CordicInvGain = 36'sd652032874;
  localparam logic signed [CordicW-1:0] HalfTurn      = 36'sd2147483648;
  localparam logic signed [CordicW-1:0] QuarterTurn   = 36'sd1073741824;
  localparam logic        [32:0]        EighthTurn    = 33'd536870912;
  localparam logic        [63:0]        CloseDist2    = 64'd429496;

  typedef enum logic {
    KIND_WAYPOINT = 1'b0,
    KIND_TICK     = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_NO_PATH = 2'd0,
    ST_GOAL    = 2'd1,
    ST_TRACK   = 2'd2,
    ST_CLOSE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LOOKAHEAD  = 2'd0,
    REG_GOAL_TOL   = 2'd1,
    REG_CRUISE     = 2'd2,
    REG_TURN_LIMIT = 2'd3
  } reg_idx_e;

  typedef enum logic {
    CORDIC_VEC = 1'b0,
    CORDIC_ROT = 1'b1
  } cordic_mode_e;

  typedef struct packed {
    cordic_mode_e               mode;
    logic signed [CordicW-1:0]  x;
    logic signed [CordicW-1:0]  y;
    logic signed [CordicW-1:0]  z;
  } cordic_req_t;

  typedef enum logic [1:0] {
    PH_GOAL,
    PH_SCAN_NEAR,
    PH_SCAN_AHEAD
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIMG,
    S_LIML,
    S_LIMW,
    S_RD,
    S_DX,
    S_SQX,
    S_SQY,
    S_EVAL,
    S_TGT,
    S_HSQX,
    S_HSQY,
    S_HSUM,
    S_SQRT,
    S_QA,
    S_QB,
    S_QC,
    S_QD,
    S_QE,
    S_YAW,
    S_ANG_ST,
    S_ANG,
    S_SIN_ST,
    S_SIN,
    S_MULV,
    S_DIVI,
    S_DIV,
    S_OMEGA,
    S_FIN
  } state_e;

  // atan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [31:0] cordic_atan(input logic [CordicStepW-1:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/pppt_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pppt_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring gives the binary
// angle of (x, y), rotation gives the sine of a binary angle in Q2.30.
// ----------------------------------------------------------------------------
module pppt_cordic
  import pppt_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire cordic_req_t               req_i,
  output logic                           done_o,
  output logic signed [CordicW-1:0]      result_o
);

  logic                       busy_q, done_q;
  logic [CordicStepW-1:0]     step_q;
  cordic_mode_e               mode_q;
  logic                       zero_q;
  logic signed [CordicW-1:0]  x_q, y_q, z_q;

  logic signed [CordicW-1:0]  x_sh, y_sh, atan_w;
  logic                       rot_neg;
  logic signed [CordicW-1:0]  px, py, pz;
  logic                       pzero;

  assign x_sh   = x_q >>> step_q;
  assign y_sh   = y_q >>> step_q;
  assign atan_w = $signed({{(CordicW-32){1'b0}}, cordic_atan(step_q)});
  // rot_neg: x - y', y + x', z - atan
  assign rot_neg = (mode_q == CORDIC_VEC) ? !(y_q > 0) : (z_q >= 0);

  always_comb begin
    px    = CordicInvGain;
    py    = '0;
    pz    = req_i.z;
    pzero = 1'b0;
    unique case (req_i.mode)
      CORDIC_VEC: begin
        pzero = (req_i.x == 0) && (req_i.y == 0);
        if (req_i.x < 0) begin
          px = -req_i.x;
          py = -req_i.y;
          pz = HalfTurn;
        end else begin
          px = req_i.x;
          py = req_i.y;
          pz = '0;
        end
      end
      CORDIC_ROT: begin
        // fold into [-pi/2, pi/2]
        if (req_i.z > QuarterTurn) begin
          pz = HalfTurn - req_i.z;
        end else if (req_i.z < -QuarterTurn) begin
          pz = -HalfTurn - req_i.z;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == CordicStepW'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= req_i.mode;
      zero_q <= pzero;
      x_q    <= px;
      y_q    <= py;
      z_q    <= pz;
    end else if (busy_q) begin
      if (rot_neg) begin
        x_q <= x_q - y_sh;
        y_q <= y_q + x_sh;
        z_q <= z_q - atan_w;
      end else begin
        x_q <= x_q + y_sh;
        y_q <= y_q - x_sh;
        z_q <= z_q + atan_w;
      end
    end
  end

  assign done_o = done_q;

  always_comb begin
    if (mode_q == CORDIC_VEC) begin
      result_o = zero_q ? '0 : $signed({{(CordicW-32){1'b0}}, z_q[31:0]});
    end else begin
      result_o = y_q;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pure_pursuit_path_tracker_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pure_pursuit_path_tracker_unit
// Pure pursuit steering: waypoint store, nearest/lookahead scans, CORDIC
// heading, and turn rate from a bit-serial root and divider.
// ----------------------------------------------------------------------------
// Input stream s_axis: tuser is the item kind (waypoint load or control tick).
// A waypoint is written in its accept cycle and gives no result; the unit is
// ready again on the next cycle. A tick gives exactly one result on m_axis,
// whose tuser carries the status and tdata the speed, turn rate and target.
// A tick runs on one shared 33x33 multiplier, one CORDIC and a sequencer:
// each waypoint visit is a memory read, a difference, two squares and a
// compare, and a tick visits the last waypoint plus up to two passes over
// the path, then 32 root steps, three CORDIC runs and 52 divide steps; a
// target too far for a direct square is first squared at half scale.
// s_tready stays low for the whole tick.
// Results sit in an output register; if the receiver stalls, the next item is
// still taken and only the following result waits for the slot.
// Reset empties the path and loads the default gains; the waypoint memory is
// not cleared and is never read beyond the loaded count.
// Configuration writes on cfg_* are always taken; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module pure_pursuit_path_tracker_unit
  import pppt_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // pos_x[31:0], pos_y[63:32], start_new_path[64], quat_x[80:65],
  // quat_y[96:81], quat_z[112:97], quat_w[128:113], zero fill
  input  wire logic [135:0]  s_axis_tdata,
  // kind
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // linear_velocity[19:0], angular_velocity[40:20], target_index[48:41], zero fill
  output logic [55:0]        m_axis_tdata,
  // status
  output logic [1:0]         m_axis_tuser,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  state_e state_q, state_d;

  // configuration
  logic [24:0] la_q, gt_q;
  logic [19:0] cs_q, trl_q;

  // path
  logic [WpCntW-1:0] wp_cnt_q;
  logic              loaded_q;
  logic [63:0]       wp_mem [MaxWaypoints];
  logic [63:0]       rd_q;

  // tick datapath
  logic signed [31:0]  rx_q, ry_q;
  logic signed [15:0]  qx_q, qy_q, qz_q, qw_q;
  phase_e              phase_q;
  logic [WpIdxW-1:0]   idx_q, closest_q;
  logic signed [32:0]  dx_q, dy_q;
  logic [49:0]         lim_q;
  logic [63:0]         sqx_q;
  logic [64:0]         d2_q, best_q;
  logic [63:0]         sq_v_q, sq_r_q, sq_bit_q;
  logic [CordicStepW-1:0] sq_cnt_q;
  logic                halved_q;
  logic [33:0]         len_q;
  logic signed [33:0]  t_q, u_q;
  logic [31:0]         yaw_q, ang_q;
  logic signed [CordicW-1:0] s_q;
  logic [51:0]         num_q, quo_q;
  logic [48:0]         rem_q;
  logic [5:0]          div_cnt_q;

  // result and output registers
  status_e     res_st_q;
  logic [19:0] res_lin_q;
  logic [20:0] res_ang_q;
  logic [7:0]  res_tgt_q;
  logic        m_valid_q;
  status_e     m_st_q;
  logic [19:0] m_lin_q;
  logic [20:0] m_ang_q;
  logic [7:0]  m_tgt_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_q;

  logic        cordic_start, cordic_done;
  cordic_req_t cordic_req;
  logic signed [CordicW-1:0] cordic_res;

  logic in_acc, out_free;
  logic [WpIdxW-1:0] last_idx;
  logic [32:0]  ax_w, ay_w;
  logic         small_vec;
  logic [64:0]  d2_now;
  logic         d2_lt_lim, d2_lt_best;
  logic [63:0]  sq_rb;
  logic         sq_take;
  logic [49:0]  rem_sh;
  logic [47:0]  den;
  logic         div_take;
  logic [31:0]  ediff;
  logic signed [32:0] e_s;
  logic [32:0]  e_abs;
  logic signed [CordicW-1:0] s_mag;
  logic [19:0]  q_clamp;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign last_idx = WpIdxW'(wp_cnt_q - 1'b1);

  assign ax_w      = dx_q[32] ? -dx_q : dx_q;
  assign ay_w      = dy_q[32] ? -dy_q : dy_q;
  assign small_vec = (ax_w[32:31] == 2'b00) && (ay_w[32:31] == 2'b00);
  // squared distance with the carry out of the 64-bit sum
  assign d2_now     = {1'b0, sqx_q} + {1'b0, mul_q[63:0]};
  assign d2_lt_lim  = d2_now < {15'b0, lim_q};
  assign d2_lt_best = d2_now < best_q;

  assign sq_rb   = sq_r_q + sq_bit_q;
  assign sq_take = sq_v_q >= sq_rb;

  assign den      = {len_q, 14'b0};
  assign rem_sh   = {rem_q, num_q[51]};
  assign div_take = rem_sh >= {2'b0, den};

  assign ediff = ang_q - yaw_q;
  assign e_s   = {ediff[31], ediff};
  assign e_abs = e_s[32] ? -e_s : e_s;
  assign s_mag = (s_q < 0) ? -s_q : s_q;
  assign q_clamp = (quo_q > {32'b0, trl_q}) ? trl_q : quo_q[19:0];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (kind_e'(s_axis_tuser) == KIND_TICK)) begin
          if (!loaded_q || (wp_cnt_q == '0)) state_d = S_FIN;
          else                               state_d = S_LIMG;
        end
      end
      S_LIMG, S_LIML: state_d = S_LIMW;
      S_LIMW:         state_d = S_RD;
      S_RD:           state_d = S_DX;
      S_DX:           state_d = S_SQX;
      S_SQX:          state_d = S_SQY;
      S_SQY:          state_d = S_EVAL;
      S_EVAL: begin
        unique case (phase_q)
          PH_GOAL:      state_d = d2_lt_lim ? S_FIN : S_RD;
          PH_SCAN_NEAR: state_d = (idx_q == last_idx) ? S_LIML : S_RD;
          PH_SCAN_AHEAD: begin
            state_d = (!d2_lt_lim || (idx_q == last_idx)) ? S_TGT : S_RD;
          end
          default:      state_d = S_IDLE;
        endcase
      end
      S_TGT: begin
        if (small_vec) state_d = (d2_q[63:0] <= CloseDist2) ? S_FIN : S_SQRT;
        else           state_d = S_HSQX;
      end
      S_HSQX:   state_d = S_HSQY;
      S_HSQY:   state_d = S_HSUM;
      S_HSUM:   state_d = S_SQRT;
      S_SQRT:   state_d = (sq_cnt_q == '1) ? S_QA : S_SQRT;
      S_QA:     state_d = S_QB;
      S_QB:     state_d = S_QC;
      S_QC:     state_d = S_QD;
      S_QD:     state_d = S_QE;
      S_QE:     state_d = S_YAW;
      S_YAW:    state_d = cordic_done ? S_ANG_ST : S_YAW;
      S_ANG_ST: state_d = S_ANG;
      S_ANG:    state_d = cordic_done ? S_SIN_ST : S_ANG;
      S_SIN_ST: state_d = S_SIN;
      S_SIN:    state_d = cordic_done ? S_MULV : S_SIN;
      S_MULV:   state_d = S_DIVI;
      S_DIVI:   state_d = S_DIV;
      S_DIV:    state_d = (div_cnt_q == 6'd51) ? S_OMEGA : S_DIV;
      S_OMEGA:  state_d = S_FIN;
      S_FIN:    state_d = out_free ? S_IDLE : S_FIN;
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------- control outputs
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    mul_a         = '0;
    mul_b         = '0;
    cordic_start  = 1'b0;
    cordic_req    = '{mode: CORDIC_VEC, x: '0, y: '0, z: '0};
    unique case (state_q)
      S_LIMG: begin
        mul_a = $signed({8'b0, gt_q});
        mul_b = $signed({8'b0, gt_q});
      end
      S_LIML: begin
        mul_a = $signed({8'b0, la_q});
        mul_b = $signed({8'b0, la_q});
      end
      S_SQX: begin
        mul_a = $signed({1'b0, ax_w[31:0]});
        mul_b = $signed({1'b0, ax_w[31:0]});
      end
      S_SQY: begin
        mul_a = $signed({1'b0, ay_w[31:0]});
        mul_b = $signed({1'b0, ay_w[31:0]});
      end
      S_HSQX: begin
        mul_a = $signed({1'b0, ax_w[32:1]});
        mul_b = $signed({1'b0, ax_w[32:1]});
      end
      S_HSQY: begin
        mul_a = $signed({1'b0, ay_w[32:1]});
        mul_b = $signed({1'b0, ay_w[32:1]});
      end
      S_QA: begin
        mul_a = 33'(qy_q);
        mul_b = 33'(qy_q);
      end
      S_QB: begin
        mul_a = 33'(qz_q);
        mul_b = 33'(qz_q);
      end
      S_QC: begin
        mul_a = 33'(qw_q);
        mul_b = 33'(qz_q);
      end
      S_QD: begin
        mul_a = 33'(qx_q);
        mul_b = 33'(qy_q);
      end
      S_QE: begin
        // yaw = atan2(2(wz+xy), 1 - 2(y^2+z^2)) at Q2.28
        cordic_start = 1'b1;
        cordic_req.mode = CORDIC_VEC;
        cordic_req.x = (CordicW'(36'sd268435456)) - (CordicW'(t_q) <<< 1);
        cordic_req.y = CordicW'(u_q + $signed(mul_q[33:0])) <<< 1;
      end
      S_ANG_ST: begin
        cordic_start = 1'b1;
        cordic_req.mode = CORDIC_VEC;
        cordic_req.x = CordicW'(dx_q);
        cordic_req.y = CordicW'(dy_q);
      end
      S_SIN_ST: begin
        cordic_start = 1'b1;
        cordic_req.mode = CORDIC_ROT;
        cordic_req.z = CordicW'(e_s);
      end
      S_MULV: begin
        mul_a = $signed({13'b0, cs_q});
        mul_b = $signed({1'b0, s_mag[31:0]});
      end
      default: ;
    endcase
  end

  pppt_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_start),
    .req_i    (cordic_req),
    .done_o   (cordic_done),
    .result_o (cordic_res)
  );

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  // waypoint memory
  logic [WpCntW-1:0] wr_base;
  logic              wr_en;
  assign wr_base = s_axis_tdata[64] ? '0 : wp_cnt_q;
  assign wr_en   = in_acc && (kind_e'(s_axis_tuser) == KIND_WAYPOINT)
                   && (wr_base < WpCntW'(MaxWaypoints));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wp_mem[wr_base[WpIdxW-1:0]] <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD) begin
      rd_q <= wp_mem[idx_q];
    end
  end

  // ------------------------------------------------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      la_q      <= 25'd65536;
      gt_q      <= 25'd19661;
      cs_q      <= 20'd81920;
      trl_q     <= 20'd163840;
      wp_cnt_q  <= '0;
      loaded_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && (cfg_index_i[7:2] == 6'd0)) begin
        unique case (reg_idx_e'(cfg_index_i[1:0]))
          REG_LOOKAHEAD:  la_q  <= cfg_data_i[24:0];
          REG_GOAL_TOL:   gt_q  <= cfg_data_i[24:0];
          REG_CRUISE:     cs_q  <= cfg_data_i[19:0];
          REG_TURN_LIMIT: trl_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (in_acc && (kind_e'(s_axis_tuser) == KIND_WAYPOINT)) begin
        loaded_q <= 1'b1;
        wp_cnt_q <= wr_en ? wr_base + 1'b1 : wr_base;
      end
      if (state_q == S_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        rx_q <= $signed(s_axis_tdata[31:0]);
        ry_q <= $signed(s_axis_tdata[63:32]);
        qx_q <= $signed(s_axis_tdata[80:65]);
        qy_q <= $signed(s_axis_tdata[96:81]);
        qz_q <= $signed(s_axis_tdata[112:97]);
        qw_q <= $signed(s_axis_tdata[128:113]);
        res_st_q  <= ST_NO_PATH;
        res_lin_q <= '0;
        res_ang_q <= '0;
        res_tgt_q <= '0;
      end
      S_LIMG: begin
        phase_q <= PH_GOAL;
        idx_q   <= last_idx;
      end
      S_LIML: begin
        phase_q <= PH_SCAN_AHEAD;
        idx_q   <= closest_q;
      end
      S_LIMW: lim_q <= mul_q[49:0];
      S_DX: begin
        dx_q <= {rd_q[63], rd_q[63:32]} - {rx_q[31], rx_q};
        dy_q <= {rd_q[31], rd_q[31:0]} - {ry_q[31], ry_q};
      end
      S_SQY, S_HSQY: sqx_q <= mul_q[63:0];
      S_EVAL: begin
        d2_q <= d2_now;
        unique case (phase_q)
          PH_GOAL: begin
            if (d2_lt_lim) begin
              res_st_q <= ST_GOAL;
            end else begin
              phase_q <= PH_SCAN_NEAR;
              idx_q   <= '0;
            end
          end
          PH_SCAN_NEAR: begin
            if ((idx_q == '0) || d2_lt_best) begin
              best_q    <= d2_now;
              closest_q <= idx_q;
            end
            idx_q <= idx_q + 1'b1;
          end
          PH_SCAN_AHEAD: begin
            if (d2_lt_lim && (idx_q != last_idx)) idx_q <= idx_q + 1'b1;
          end
          default: ;
        endcase
      end
      S_TGT: begin
        res_tgt_q <= 8'(idx_q);
        res_st_q  <= ST_CLOSE;
        sq_v_q    <= d2_q[63:0];
        sq_r_q    <= '0;
        sq_bit_q  <= 64'h4000_0000_0000_0000;
        sq_cnt_q  <= '0;
        halved_q  <= 1'b0;
      end
      S_HSUM: begin
        sq_v_q   <= sqx_q + mul_q[63:0];
        halved_q <= 1'b1;
      end
      S_SQRT: begin
        if (sq_take) begin
          sq_v_q <= sq_v_q - sq_rb;
          sq_r_q <= (sq_r_q >> 1) + sq_bit_q;
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        sq_cnt_q <= sq_cnt_q + 1'b1;
        if (sq_cnt_q == '1) begin
          if (sq_take) len_q <= halved_q ? {sq_r_q[33:1] + sq_bit_q[32:0], 1'b0}
                                         : 34'((sq_r_q >> 1) + sq_bit_q);
          else         len_q <= halved_q ? {sq_r_q[33:1], 1'b0}
                                         : 34'(sq_r_q >> 1);
        end
      end
      S_QB: t_q <= mul_q[33:0];
      S_QC: t_q <= t_q + mul_q[33:0];
      S_QD: u_q <= mul_q[33:0];
      S_YAW: if (cordic_done) yaw_q <= cordic_res[31:0];
      S_ANG: if (cordic_done) ang_q <= cordic_res[31:0];
      S_SIN: if (cordic_done) s_q <= cordic_res;
      S_DIVI: begin
        num_q     <= {mul_q[50:0], 1'b0};
        rem_q     <= '0;
        quo_q     <= '0;
        div_cnt_q <= '0;
      end
      S_DIV: begin
        rem_q     <= div_take ? 49'(rem_sh - {2'b0, den}) : rem_sh[48:0];
        quo_q     <= {quo_q[50:0], div_take};
        num_q     <= num_q << 1;
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      S_OMEGA: begin
        res_st_q  <= ST_TRACK;
        res_lin_q <= (e_abs > EighthTurn) ? (cs_q >> 1) : cs_q;
        res_ang_q <= (s_q < 0) ? -{1'b0, q_clamp} : {1'b0, q_clamp};
      end
      S_FIN: begin
        if (out_free) begin
          m_st_q  <= res_st_q;
          m_lin_q <= res_lin_q;
          m_ang_q <= res_ang_q;
          m_tgt_q <= res_tgt_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tdata  = {7'b0, m_tgt_q, m_ang_q, m_lin_q};
  assign cfg_ready_o   = 1'b1;

  // -------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_cnt_q <= WpCntW'(MaxWaypoints))
    else $error("waypoint count beyond store depth");

  a_no_path_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NO_PATH) |-> m_axis_tdata == '0)
    else $error("no-path result carries data");

  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && m_valid_q && !m_axis_tready |=> state_q == S_FIN)
    else $error("result dropped while output slot busy");

  a_cordic_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_start |=> !cordic_done)
    else $error("cordic finished right after start");

endmodule
`default_nettype wire
